@@ hdl/qspe_pkg.sv @@
// ----------------------------------------------------------------------------
// qspe_pkg
// Types and constants for the queue-driven shortest path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qspe_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_SOLVE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [20:0] DIST_MAX = 21'h1FFFFF;
    localparam logic [6:0]  NODE_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]         command;
        logic [6:0]         edge_from;
        logic [6:0]         edge_to;
        logic signed [15:0] edge_weight;
        logic [6:0]         source_node;
    } item_t;

    typedef struct packed {
        logic [6:0]  node;
        logic [20:0] distance;
        logic        reachable;
        logic [8:0]  pred_edge;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/qspe_ram.sv @@
// ----------------------------------------------------------------------------
// qspe_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module qspe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/queue_shortest_path_engine_unit.sv @@
// ----------------------------------------------------------------------------
// queue_shortest_path_engine_unit
// Queue-based Bellman-Ford (SPFA) engine with edge store and per-node results.
// ----------------------------------------------------------------------------
// channel   signals                         transfer when
// item      item_valid, item_ready, item    item_valid & item_ready
// result    result_valid, result_ready, ... result_valid & result_ready
// config    cfg_we, cfg_data                cfg_we
//
// Clear resets the edge store on accept. Add reads the adjacency head, then writes the edge.
// Solve: after accept, each popped node goes through pop, queue read, node read
// and list end; each edge visited is read and checked, then compared if it is
// relaxable; a final pop ends the search, then each result is staged and loaded.
// Reset clears list and node valid bits at once; no clearing pass.
// A stalled result holds the engine only during the output phase.
`default_nettype none

module queue_shortest_path_engine_unit #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 512
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire qspe_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output qspe_pkg::result_t      result,
    input  wire logic              cfg_we,
    input  wire logic [6:0]        cfg_data
);

    import qspe_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int QAW = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int EDW = NW + 16 + EW;
    localparam int NDW = 21 + EAW;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_POP, S_ULOAD, S_UDIST, S_EREAD, S_EDATA, S_VCMP,
        S_ORD, S_OLOAD
    } state_t;

    state_t              state_reg;
    logic [6:0]          nc_reg;
    logic [NW-1:0]       n_reg;
    logic [EW-1:0]       total_reg;
    logic [MAX_NODES:0]  lvalid_reg;
    logic [MAX_NODES:0]  nvalid_reg;
    logic [MAX_NODES:0]  queued_reg;
    logic [QAW-1:0]      head_reg;
    logic [QAW-1:0]      tail_reg;
    logic [NW-1:0]       count_reg;
    logic [NW-1:0]       from_reg;
    logic [NW-1:0]       to_reg;
    logic [15:0]         wt_reg;
    logic [NW-1:0]       u_reg;
    logic [NW-1:0]       v_reg;
    logic [20:0]         dist_u_reg;
    logic [20:0]         sum_reg;
    logic [EW-1:0]       e_reg;
    logic [EW-1:0]       link_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    // RAM ports
    logic            l_we, e_we, n_we, q_we;
    logic [NW-1:0]   l_waddr, l_raddr, n_waddr, n_raddr;
    logic [EW-1:0]   l_wdata, l_rdata;
    logic [EAW-1:0]  e_waddr, e_raddr;
    logic [EDW-1:0]  e_wdata, e_rdata;
    logic [NDW-1:0]  n_wdata, n_rdata;
    logic [QAW-1:0]  q_waddr, q_raddr;
    logic [NW-1:0]   q_wdata, q_rdata;

    logic [NW-1:0]   n_eff;
    logic [NW-1:0]   src_idx;
    logic            src_ok;
    logic [MAX_NODES:0] src_mask;
    logic            add_ok;
    logic            accept;
    logic [NW-1:0]   e_head;
    logic [15:0]     e_cost;
    logic [EW-1:0]   e_link;
    logic [21:0]     sum_wide;
    logic [20:0]     sum_sat;
    logic            e_skip;
    logic            upd;
    logic            enq;
    logic [EW-1:0]   new_link;
    logic            out_free;

    function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] x);
        wrap_inc = (x == QAW'(MAX_NODES - 1)) ? '0 : x + 1'b1;
    endfunction

    qspe_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_list (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );
    qspe_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    qspe_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES + 1)) u_node (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );
    qspe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    always_comb
    begin
        if (nc_reg == 7'd0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(nc_reg) > MAX_NODES)
        begin
            n_eff = NW'(MAX_NODES);
        end
        else
        begin
            n_eff = NW'(nc_reg);
        end
    end

    assign src_idx  = NW'(item.source_node);
    assign src_ok   = (item.source_node != 7'd0) && (int'(item.source_node) <= int'(n_eff));
    // only the source starts reached and queued
    assign src_mask = src_ok ? ((MAX_NODES + 1)'(1) << src_idx) : '0;
    assign add_ok   = (int'(total_reg) < MAX_EDGES)
                   && (item.edge_from != 7'd0) && (int'(item.edge_from) <= MAX_NODES)
                   && (item.edge_to != 7'd0) && (int'(item.edge_to) <= MAX_NODES);

    assign e_head   = e_rdata[EDW-1 -: NW];
    assign e_cost   = e_rdata[EW+15 -: 16];
    assign e_link   = e_rdata[EW-1:0];
    assign sum_wide = {1'b0, dist_u_reg} + {7'd0, e_cost[14:0]};
    assign sum_sat  = sum_wide[21] ? DIST_MAX : sum_wide[20:0];
    // broken weight or head outside the active node range
    assign e_skip   = e_cost[15] || (e_cost == 16'd0) || (e_head == '0) || (e_head > n_reg);
    assign upd      = !nvalid_reg[v_reg] || (n_rdata[NDW-1 -: 21] > sum_reg);
    assign enq      = upd && !queued_reg[v_reg] && (int'(count_reg) < MAX_NODES);
    assign new_link = lvalid_reg[from_reg] ? l_rdata : EW'(MAX_EDGES);

    always_comb
    begin
        l_we    = (state_reg == S_ADD);
        l_waddr = from_reg;
        l_wdata = total_reg;
        l_raddr = (state_reg == S_IDLE) ? NW'(item.edge_from) : q_rdata;

        e_we    = (state_reg == S_ADD);
        e_waddr = total_reg[EAW-1:0];
        e_wdata = {to_reg, wt_reg, new_link};
        e_raddr = e_reg[EAW-1:0];

        n_we    = 1'b0;
        n_waddr = v_reg;
        n_wdata = {sum_reg, e_reg[EAW-1:0]};
        n_raddr = v_reg;

        q_we    = 1'b0;
        q_waddr = tail_reg;
        q_wdata = v_reg;
        q_raddr = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.command == CMD_SOLVE && src_ok)
                begin
                    n_we    = 1'b1;
                    n_waddr = src_idx;
                    n_wdata = '0;
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = src_idx;
                end
            end
            S_ULOAD:
            begin
                n_raddr = q_rdata;
            end
            S_EDATA:
            begin
                n_raddr = e_head;
            end
            S_VCMP:
            begin
                n_we = upd;
                q_we = enq;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            nc_reg           <= NODE_COUNT_RESET;
            total_reg        <= '0;
            lvalid_reg       <= '0;
            nvalid_reg       <= '0;
            queued_reg       <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                nc_reg <= cfg_data;
            end
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cmd_t'(item.command))
                            CMD_CLEAR:
                            begin
                                total_reg  <= '0;
                                lvalid_reg <= '0;
                            end
                            CMD_ADD:
                            begin
                                if (add_ok)
                                begin
                                    from_reg  <= NW'(item.edge_from);
                                    to_reg    <= NW'(item.edge_to);
                                    wt_reg    <= item.edge_weight;
                                    state_reg <= S_ADD;
                                end
                            end
                            CMD_SOLVE:
                            begin
                                n_reg      <= n_eff;
                                nvalid_reg <= src_mask;
                                queued_reg <= src_mask;
                                head_reg   <= '0;
                                if (src_ok)
                                begin
                                    tail_reg  <= wrap_inc('0);
                                    count_reg <= NW'(1);
                                end
                                else
                                begin
                                    tail_reg  <= '0;
                                    count_reg <= '0;
                                end
                                state_reg <= S_POP;
                            end
                            CMD_NONE:
                            begin
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    lvalid_reg[from_reg] <= 1'b1;
                    total_reg <= total_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                S_POP:
                begin
                    if (count_reg == '0)
                    begin
                        v_reg     <= NW'(1);
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        head_reg  <= wrap_inc(head_reg);
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_ULOAD;
                    end
                end
                S_ULOAD:
                begin
                    u_reg <= q_rdata;
                    queued_reg[q_rdata] <= 1'b0;
                    state_reg <= S_UDIST;
                end
                S_UDIST:
                begin
                    dist_u_reg <= n_rdata[NDW-1 -: 21];
                    e_reg      <= lvalid_reg[u_reg] ? l_rdata : EW'(MAX_EDGES);
                    state_reg  <= S_EREAD;
                end
                S_EREAD:
                begin
                    state_reg <= (e_reg < total_reg) ? S_EDATA : S_POP;
                end
                S_EDATA:
                begin
                    if (e_skip)
                    begin
                        e_reg     <= e_link;
                        state_reg <= S_EREAD;
                    end
                    else
                    begin
                        v_reg     <= e_head;
                        sum_reg   <= sum_sat;
                        link_reg  <= e_link;
                        state_reg <= S_VCMP;
                    end
                end
                S_VCMP:
                begin
                    if (upd)
                    begin
                        nvalid_reg[v_reg] <= 1'b1;
                    end
                    if (enq)
                    begin
                        queued_reg[v_reg] <= 1'b1;
                        tail_reg  <= wrap_inc(tail_reg);
                        count_reg <= count_reg + 1'b1;
                    end
                    e_reg     <= link_reg;
                    state_reg <= S_EREAD;
                end
                S_ORD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_OLOAD;
                    end
                end
                S_OLOAD:
                begin
                    result_valid_reg     <= 1'b1;
                    result_reg.node      <= 7'(v_reg);
                    result_reg.reachable <= nvalid_reg[v_reg];
                    result_reg.distance  <= nvalid_reg[v_reg] ? n_rdata[NDW-1 -: 21] : 21'd0;
                    result_reg.pred_edge <= nvalid_reg[v_reg] ? 9'(n_rdata[EAW-1:0]) : 9'd0;
                    result_reg.last      <= (v_reg == n_reg);
                    if (v_reg == n_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        v_reg     <= v_reg + 1'b1;
                        state_reg <= S_ORD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_NODES)
        else $error("work queue count overflow");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(total_reg) <= MAX_EDGES)
        else $error("edge total overflow");

    a_enq_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VCMP && q_we) |-> !queued_reg[v_reg])
        else $error("node queued twice");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OLOAD) |-> !result_valid_reg)
        else $error("result overwritten");

endmodule

`default_nettype wire

@@ tb/sv/queue_shortest_path_engine_unit_tb.sv @@
// ----------------------------------------------------------------------------
// queue_shortest_path_engine_unit_tb
// Drives edge loads and solves into the shortest path engine across several
// node counts, predicts every per-node result and checks each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module queue_shortest_path_engine_unit_tb;
    import qspe_pkg::*;

    localparam int NODES = 64;
    localparam int EDGES = 512;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic cfg_we;
    logic [6:0] cfg_data;

    queue_shortest_path_engine_unit #(.MAX_NODES(NODES), .MAX_EDGES(EDGES)) dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // predictor state
    logic [6:0]  nodes_cfg;
    logic [6:0]  e_tail [EDGES];
    logic [6:0]  e_head [EDGES];
    logic [15:0] e_cost [EDGES];
    int          e_link [EDGES];
    int          e_total;
    int          list_head [NODES + 1];
    int          dist_v [NODES + 1];
    bit          reach_v [NODES + 1];
    int          pred_v [NODES + 1];
    bit          in_queue [NODES + 1];

    item_t   pending_items [$];
    result_t expected_results [$];

    int errors = 0;
    int checked = 0;
    int solves = 0;
    bit long_hold = 0;
    bit sender_hold = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit stimulus_done = 0;

    function automatic void clear_graph();
        e_total = 0;
        for (int i = 0; i <= NODES; i++) list_head[i] = EDGES;
    endfunction

    function automatic void queue_item(item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void solve_paths(int src, int n);
        int wq [NODES];
        int hd;
        int cnt;
        int u;
        int e;
        int v;
        int w;
        int sum;
        hd = 0;
        cnt = 0;
        for (int i = 0; i <= NODES; i++)
        begin
            dist_v[i] = 0; reach_v[i] = 0; pred_v[i] = 0; in_queue[i] = 0;
        end
        if (src == 0 || src > n) return;
        reach_v[src] = 1;
        in_queue[src] = 1;
        wq[0] = src;
        cnt = 1;
        while (cnt != 0)
        begin
            u = wq[hd];
            hd = (hd + 1) % NODES;
            cnt--;
            in_queue[u] = 0;
            e = list_head[u];
            while (e < e_total)
            begin
                v = e_head[e];
                w = e_cost[e];
                if (!(e_cost[e][15] || w == 0 || v == 0 || v > n))
                begin
                    sum = dist_v[u] + w;
                    if (sum > int'(DIST_MAX)) sum = DIST_MAX;
                    if (!reach_v[v] || dist_v[v] > sum)
                    begin
                        dist_v[v] = sum;
                        reach_v[v] = 1;
                        pred_v[v] = e;
                        if (!in_queue[v] && cnt < NODES)
                        begin
                            in_queue[v] = 1;
                            wq[(hd + cnt) % NODES] = v;
                            cnt++;
                        end
                    end
                end
                e = e_link[e];
            end
        end
    endfunction

    function automatic void predict_item(item_t it);
        int n;
        result_t r;
        case (it.command)
            CMD_CLEAR: clear_graph();
            CMD_ADD:
            begin
                if (e_total < EDGES && it.edge_from != 0 && it.edge_from <= NODES
                    && it.edge_to != 0 && it.edge_to <= NODES)
                begin
                    e_tail[e_total] = it.edge_from;
                    e_head[e_total] = it.edge_to;
                    e_cost[e_total] = it.edge_weight;
                    e_link[e_total] = list_head[it.edge_from];
                    list_head[it.edge_from] = e_total;
                    e_total++;
                end
            end
            CMD_SOLVE:
            begin
                n = (nodes_cfg == 0) ? 1 : ((nodes_cfg > NODES) ? NODES : nodes_cfg);
                solve_paths(it.source_node, n);
                solves++;
                for (int v = 1; v <= n; v++)
                begin
                    r.node = v[6:0];
                    r.reachable = reach_v[v];
                    r.distance = reach_v[v] ? dist_v[v][20:0] : '0;
                    r.pred_edge = reach_v[v] ? pred_v[v][8:0] : '0;
                    r.last = (v == n);
                    expected_results = {expected_results, r};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic item_t make_item(cmd_t c, int f, int t, int w, int s);
        item_t it;
        it.command = c;
        it.edge_from = f[6:0];
        it.edge_to = t[6:0];
        it.edge_weight = w[15:0];
        it.source_node = s[6:0];
        return it;
    endfunction

    function automatic item_t random_add(int n);
        int w;
        w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(1, 200));
        if ($urandom_range(0, 19) == 0) w = 32767;
        return make_item(CMD_ADD, $urandom_range(1, n), $urandom_range(1, n), w,
                         $urandom_range(0, 127));
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!item_valid || item_ready)
        begin
            if (item_valid) predict_item(item);
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0 && !sender_hold)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (long_hold)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result node %0d", result.node);
            end
            else
            begin
                result_t x;
                x = expected_results.pop_front();
                checked++;
                if (x !== result)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp n=%0d d=%0d r=%0b p=%0d l=%0b",
                                  " got n=%0d d=%0d r=%0b p=%0d l=%0b"},
                                 x.node, x.distance, x.reachable, x.pred_edge, x.last,
                                 result.node, result.distance, result.reachable,
                                 result.pred_edge, result.last);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_nodes(int n);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= n[6:0];
        nodes_cfg = n[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (solves >= 3);
        long_hold = 1;
        repeat (3000) @(posedge clk);
        long_hold = 0;
    end

    initial
    begin
        int n;
        int sizes [6] = '{64, 1, 2, 127, 0, 8};
        rst_n = 0;
        cfg_we = 0;
        cfg_data = '0;
        nodes_cfg = NODE_COUNT_RESET;
        clear_graph();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, broken edges, bad endpoints, bad source
        queue_item(make_item(CMD_ADD, 1, 2, 32767, 0));
        queue_item(make_item(CMD_ADD, 2, 3, 32767, 127));
        queue_item(make_item(CMD_ADD, 1, 3, 5, 0));
        queue_item(make_item(CMD_ADD, 3, 64, 1, 0));
        queue_item(make_item(CMD_ADD, 1, 4, 0, 0));
        queue_item(make_item(CMD_ADD, 1, 5, -32768, 0));
        queue_item(make_item(CMD_ADD, 1, 6, -1, 0));
        queue_item(make_item(CMD_ADD, 0, 6, 3, 0));
        queue_item(make_item(CMD_ADD, 65, 6, 3, 0));
        queue_item(make_item(CMD_ADD, 6, 127, 3, 0));
        queue_item(make_item(CMD_ADD, 64, 1, 2, 0));
        queue_item(make_item(CMD_NONE, 127, 127, -1, 127));
        queue_item(make_item(CMD_SOLVE, 0, 0, 0, 1));
        queue_item(make_item(CMD_SOLVE, 127, 127, -1, 64));
        queue_item(make_item(CMD_SOLVE, 0, 0, 0, 0));
        queue_item(make_item(CMD_SOLVE, 0, 0, 0, 65));
        queue_item(make_item(CMD_SOLVE, 0, 0, 0, 127));
        queue_item(make_item(CMD_CLEAR, 0, 0, 0, 0));
        queue_item(make_item(CMD_SOLVE, 0, 0, 0, 1));
        wait_drained();

        // random phases across node counts; pause to drain after each
        for (int ph = 0; ph < 6; ph++)
        begin
            write_nodes(sizes[ph]);
            n = (sizes[ph] == 0) ? 1 : ((sizes[ph] > 64) ? 64 : sizes[ph]);
            for (int k = 0; k < 23; k++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_item(make_item(CMD_SOLVE, 0, 0, 0, $urandom_range(0, 127)));
                    1, 2: queue_item(make_item(CMD_SOLVE,
                                               $urandom_range(0, 127),
                                               $urandom_range(0, 127),
                                               $urandom_range(0, 65535),
                                               $urandom_range(1, n)));
                    3: queue_item(make_item(cmd_t'($urandom_range(0, 3)),
                                            $urandom_range(0, 127),
                                            $urandom_range(0, 127),
                                            $urandom_range(0, 65535),
                                            $urandom_range(0, 127)));
                    default: queue_item(random_add(($urandom_range(0, 4) == 0) ? 64 : n));
                endcase
            end
            sender_hold = (ph == 2);
            repeat (20) @(posedge clk);
            sender_hold = 0;
            wait_drained();
        end
        stimulus_done = 1;

        $display("covered %0d solves, %0d results checked, node counts 0..127",
                 solves, checked);
        if (errors == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
